>>> hdl/sir90_pkg.sv
package sir90_pkg;

	// fixed field widths
	localparam int PIX_W = 32;
	localparam int CFG_W = 7;

	// defaults
	localparam int DEFAULT_MAX_SIDE = 64;
	localparam int SIDE_RESET       = 64;
	localparam int QUEUE_DEPTH      = 2;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_ERR   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      last;
	} cmd_ctl_t;

	localparam int CMD_CTL_W = $bits(cmd_ctl_t);

	typedef struct packed {
		logic                    op;
		logic signed [PIX_W-1:0] pixel_in;
	} in_item_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_out;
		logic                    last;
		logic                    status;
	} out_item_t;

endpackage

>>> hdl/square_image_rotate_90.sv
// channel   | beat                      | handshake
// ----------+---------------------------+------------------------------------
// item      | op, pixel_in              | push / full, taken on push & !full
// result    | pixel_out, last, status   | empty / pop, taken on pop & !empty
// config    | cfg_data (side_length)    | cfg_we, taken on every cfg_we edge
//
// one beat per clock in both directions when neither side stalls
// a drain beat passes through the command queue, the read stage and the output register before it shows on result
// the frame store is one single-port ram, used by write and read commands but not by error commands
// reset gives side 64 (clamped to MAX_SIDE) and an empty frame, no clearing pass
// full rises only when the command queue backs up behind a stalled result
module square_image_rotate_90 import sir90_pkg::*; #(
	parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             push,
	input  in_item_t         item,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output out_item_t        result
);

	localparam int AW  = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int QW  = CMD_CTL_W + AW + PIX_W;

	// front to queue
	logic             fq_push;
	cmd_ctl_t         fq_ctl;
	logic [AW-1:0]    fq_addr;
	logic [PIX_W-1:0] fq_data;
	logic             q_full;

	// queue to back
	logic [QW-1:0]    q_rd;
	logic             q_empty;
	logic             q_pop;
	cmd_ctl_t         bq_ctl;
	logic [AW-1:0]    bq_addr;
	logic [PIX_W-1:0] bq_data;

	// front: counts loads, walks the rotated readout, queues each beat as a command but drops writes once loaded
	sir90_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.push    (push),
		.item    (item),
		.full    (full),
		.q_full  (q_full),
		.q_push  (fq_push),
		.q_ctl   (fq_ctl),
		.q_addr  (fq_addr),
		.q_data  (fq_data)
	);

	// short command queue, keeps writes and reads in order
	sir90_queue #(
		.W    (QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fq_push),
		.wr_data({fq_ctl, fq_addr, fq_data}),
		.rd_en  (q_pop),
		.rd_data(q_rd),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign {bq_ctl, bq_addr, bq_data} = q_rd;

	// back: frame store, read stage and output register
	sir90_back #(
		.MAX_SIDE(MAX_SIDE)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_ctl  (bq_ctl),
		.q_addr (bq_addr),
		.q_data (bq_data),
		.q_pop  (q_pop),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

endmodule

>>> hdl/sir90_front.sv
module sir90_front import sir90_pkg::*; #(
	parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
	localparam int AW = $clog2(MAX_SIDE * MAX_SIDE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             push,
	input  in_item_t         item,
	output logic             full,
	input  logic             q_full,
	output logic             q_push,
	output cmd_ctl_t         q_ctl,
	output logic [AW-1:0]    q_addr,
	output logic [PIX_W-1:0] q_data
);

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int PW = $clog2(MAX_SIDE);
	localparam int CW = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int NW = (SW > CFG_W) ? SW : CFG_W;
	localparam int RST_SIDE = (SIDE_RESET < MAX_SIDE) ? SIDE_RESET : MAX_SIDE;
	localparam int RST_TOTAL = RST_SIDE * RST_SIDE;

	logic [SW-1:0]   side_q;
	logic [CW-1:0]   total_q;
	logic [CW-1:0]   load_cnt_q;
	logic [PW-1:0]   row_q;
	logic [PW-1:0]   col_q;

	logic [NW-1:0]   cfg_ext;
	logic [NW-1:0]   side_clamp;
	logic [SW-1:0]   side_new;
	logic [2*SW-1:0] total_new;
	logic [PW-1:0]   side_m1;
	logic [SW-1:0]   base;
	logic [2*SW-1:0] prod;
	logic [2*SW-1:0] addr_rd;
	logic            accept;
	logic            loaded;
	logic            is_last;
	logic            col_end;

	// clamp the written side into 1..MAX_SIDE
	assign cfg_ext    = NW'(cfg_data);
	assign side_clamp = (cfg_ext == '0) ? NW'(1) :
		(cfg_ext > NW'(MAX_SIDE)) ? NW'(MAX_SIDE) : cfg_ext;
	assign side_new   = SW'(side_clamp);
	assign total_new  = (2*SW)'(side_new) * (2*SW)'(side_new);

	assign accept = push && !q_full;
	assign full   = q_full;
	assign loaded = (load_cnt_q >= total_q);

	// rotated read address: (n-1-col)*n + row
	assign side_m1 = PW'(side_q - SW'(1));
	assign base    = SW'(side_m1) - SW'(col_q);
	assign prod    = (2*SW)'(base) * (2*SW)'(side_q);
	assign addr_rd = prod + (2*SW)'(row_q);
	assign col_end = (col_q == side_m1);
	assign is_last = col_end && (row_q == side_m1);

	always_comb begin
		q_push      = 1'b0;
		q_ctl.kind  = CMD_WRITE;
		q_ctl.last  = 1'b0;
		q_addr      = AW'(load_cnt_q);
		q_data      = item.pixel_in;
		if (accept) begin
			if (item.op == 1'b0) begin
				q_push = !loaded;
			end else if (!loaded) begin
				q_push     = 1'b1;
				q_ctl.kind = CMD_ERR;
			end else begin
				q_push     = 1'b1;
				q_ctl.kind = CMD_READ;
				q_ctl.last = is_last;
				q_addr     = AW'(addr_rd);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q     <= SW'(RST_SIDE);
			total_q    <= CW'(RST_TOTAL);
			load_cnt_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else if (cfg_we) begin
			side_q     <= side_new;
			total_q    <= CW'(total_new);
			load_cnt_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else if (accept) begin
			if (item.op == 1'b0) begin
				if (!loaded) begin
					load_cnt_q <= load_cnt_q + CW'(1);
				end
			end else if (loaded) begin
				if (is_last) begin
					load_cnt_q <= '0;
					row_q      <= '0;
					col_q      <= '0;
				end else if (col_end) begin
					col_q <= '0;
					row_q <= row_q + PW'(1);
				end else begin
					col_q <= col_q + PW'(1);
				end
			end
		end
	end

endmodule

>>> hdl/sir90_queue.sv
module sir90_queue import sir90_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty,
	output logic         full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/sir90_back.sv
module sir90_back import sir90_pkg::*; #(
	parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
	localparam int AW = $clog2(MAX_SIDE * MAX_SIDE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  cmd_ctl_t         q_ctl,
	input  logic [AW-1:0]    q_addr,
	input  logic [PIX_W-1:0] q_data,
	output logic             q_pop,
	output out_item_t        result,
	output logic             empty,
	input  logic             pop
);

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;

	logic [PIX_W-1:0] frame_mem [DEPTH];

	logic             valid_s1;
	cmd_ctl_t         ctl_s1;
	logic [PIX_W-1:0] pix_s1;
	out_item_t        res_q;
	logic             res_valid_q;

	logic             adv;
	logic             is_wr;
	logic             rd_pop;
	logic             mem_rd;

	// s1 moves into the output register when that is free or being taken
	assign adv = valid_s1 && (!res_valid_q || pop);

	always_comb begin
		is_wr = 1'b0;
		unique case (q_ctl.kind) inside
			CMD_WRITE: is_wr = 1'b1;
			CMD_READ, CMD_ERR: is_wr = 1'b0;
			default: is_wr = 1'b1;
		endcase
	end

	assign q_pop  = !q_empty && (is_wr || !valid_s1 || adv);
	assign rd_pop = q_pop && !is_wr;
	assign mem_rd = rd_pop && (q_ctl.kind == CMD_READ);

	always_ff @(posedge clk) begin
		if (q_pop && is_wr) begin
			frame_mem[q_addr] <= q_data;
		end
		if (mem_rd) begin
			pix_s1 <= frame_mem[q_addr];
		end
		if (rd_pop) begin
			ctl_s1 <= q_ctl;
		end
		if (adv) begin
			res_q.pixel_out <= (ctl_s1.kind == CMD_ERR) ? '0 : pix_s1;
			res_q.last      <= ctl_s1.last;
			res_q.status    <= (ctl_s1.kind == CMD_ERR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rd_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result = res_q;
	assign empty  = !res_valid_q;

endmodule
